// File: hdl/usrc_pkg.sv
// Shared types and constants for the UTF-8 script ratio classifier.
// Used by the front decoder, the event queue, the back tally unit and the top level.
`default_nettype none

package usrc_pkg;

    localparam int TALLY_WIDTH_DEF = 16;
    localparam int LIMIT_WIDTH     = 7;
    localparam int OUT_WIDTH       = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MIN_TOTAL       = 10;
    localparam int PERCENT         = 100;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 7'd50;

    // events passed from the decoder to the tally unit
    typedef enum logic [1:0] {
        EV_LATIN   = 2'd0,
        EV_FOREIGN = 2'd1,
        EV_TERM    = 2'd2
    } ev_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

// File: hdl/usrc_front.sv
// Front part: accepts text bytes, decodes UTF-8 and classifies each character.
// Pushes one event per counted character or terminator; uses usrc_pkg.
`default_nettype none

module usrc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    byte_data,
    input  wire logic          q_full,
    output logic               byte_ready,
    output logic               ev_push,
    output usrc_pkg::ev_t      ev_code
);

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] partial_reg, partial_next;
    logic [20:0] cp;
    logic        take;
    logic        alnum;
    logic        foreign_cp;
    logic        latin_cp;

    function automatic logic in_range(input logic [20:0] v, input logic [20:0] lo,
                                      input logic [20:0] hi);
        in_range = (v >= lo) && (v <= hi);
    endfunction

    assign byte_ready = !q_full;
    assign take       = byte_valid && byte_ready;
    assign cp         = {partial_reg[14:0], byte_data[5:0]};

    assign alnum = (byte_data >= 8'h41 && byte_data <= 8'h5A) ||
                   (byte_data >= 8'h61 && byte_data <= 8'h7A) ||
                   (byte_data >= 8'h30 && byte_data <= 8'h39);

    // Arabic, Cyrillic, CJK, Kana, Hangul, Thai, Hebrew, Devanagari, Tamil
    assign foreign_cp = in_range(cp, 21'h00600, 21'h006FF) ||
                        in_range(cp, 21'h00400, 21'h004FF) ||
                        in_range(cp, 21'h04E00, 21'h09FFF) ||
                        in_range(cp, 21'h03040, 21'h030FF) ||
                        in_range(cp, 21'h0AC00, 21'h0D7A3) ||
                        in_range(cp, 21'h00E00, 21'h00E7F) ||
                        in_range(cp, 21'h00590, 21'h005FF) ||
                        in_range(cp, 21'h00900, 21'h0097F) ||
                        in_range(cp, 21'h00B80, 21'h00BFF);
    assign latin_cp = in_range(cp, 21'h000C0, 21'h0024F);

    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        ev_push      = 1'b0;
        ev_code      = usrc_pkg::EV_LATIN;
        if (take) begin
            if (byte_data == 8'h00) begin
                // terminator drops any partial sequence
                pending_next = 2'd0;
                partial_next = '0;
                ev_push      = 1'b1;
                ev_code      = usrc_pkg::EV_TERM;
            end else if (pending_reg != 2'd0) begin
                pending_next = pending_reg - 2'd1;
                partial_next = cp;
                if (pending_reg == 2'd1) begin
                    partial_next = '0;
                    if (foreign_cp) begin
                        ev_push = 1'b1;
                        ev_code = usrc_pkg::EV_FOREIGN;
                    end else if (latin_cp) begin
                        ev_push = 1'b1;
                        ev_code = usrc_pkg::EV_LATIN;
                    end
                end
            end else if (!byte_data[7]) begin
                ev_push = alnum;
                ev_code = usrc_pkg::EV_LATIN;
            end else if (byte_data[7:5] == 3'b110) begin
                partial_next = {16'd0, byte_data[4:0]};
                pending_next = 2'd1;
            end else if (byte_data[7:4] == 4'b1110) begin
                partial_next = {17'd0, byte_data[3:0]};
                pending_next = 2'd2;
            end else if (byte_data[7:3] == 5'b11110) begin
                partial_next = {18'd0, byte_data[2:0]};
                pending_next = 2'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
        end else begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/usrc_fifo.sv
// Short event queue between the decoder and the tally unit.
// Register-array FIFO of usrc_pkg::ev_t codes, depth from usrc_pkg.
`default_nettype none

module usrc_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire usrc_pkg::ev_t       push_code,
    input  wire logic                pop,
    output usrc_pkg::ev_t            pop_code,
    output usrc_pkg::q_status_t      status
);

    localparam int PtrW = $clog2(usrc_pkg::QUEUE_DEPTH);

    usrc_pkg::ev_t mem [usrc_pkg::QUEUE_DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (PtrW+1)'(usrc_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_code     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/usrc_back.sv
// Back part: tallies events, checks the foreign ratio at a terminator, holds the result.
// Ratio test without division: floor(f*100/t) > L  <=>  f*100 >= (L+1)*t. Uses usrc_pkg.
`default_nettype none

module usrc_back #(
    parameter int TALLY_WIDTH = usrc_pkg::TALLY_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [usrc_pkg::LIMIT_WIDTH-1:0]   limit,
    input  wire usrc_pkg::ev_t                      ev_code,
    input  wire usrc_pkg::q_status_t                q_status,
    output logic                                    ev_pop,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output logic                                    res_is_foreign,
    output logic                                    res_too_short,
    output logic [usrc_pkg::OUT_WIDTH-1:0]          res_foreign_total,
    output logic [usrc_pkg::OUT_WIDTH-1:0]          res_latin_total
);

    localparam int TotW = TALLY_WIDTH + 1;
    localparam int ProdW = TALLY_WIDTH + 9;
    localparam int SatW = (TALLY_WIDTH > usrc_pkg::OUT_WIDTH) ? TALLY_WIDTH
                                                              : usrc_pkg::OUT_WIDTH;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_CMP
    } state_t;

    state_t                        state_reg;
    logic [TALLY_WIDTH-1:0]        foreign_reg, latin_reg;
    logic [ProdW-1:0]              prod_f_reg, prod_t_reg;
    logic                          short_reg;
    logic                          out_valid_reg;
    logic                          out_foreign_reg, out_short_reg;
    logic [usrc_pkg::OUT_WIDTH-1:0] out_ftot_reg, out_ltot_reg;
    logic [TotW-1:0]               total;
    logic                          slot_free;

    function automatic logic [usrc_pkg::OUT_WIDTH-1:0] sat_out(
        input logic [TALLY_WIDTH-1:0] v);
        logic [SatW-1:0] ext;
        ext = SatW'(v);
        if (ext > SatW'({usrc_pkg::OUT_WIDTH{1'b1}})) begin
            sat_out = '1;
        end else begin
            sat_out = ext[usrc_pkg::OUT_WIDTH-1:0];
        end
    endfunction

    assign total     = TotW'(foreign_reg) + TotW'(latin_reg);
    assign slot_free = !out_valid_reg || res_ready;
    assign ev_pop    = (state_reg == ST_RUN) && !q_status.empty;

    assign res_valid         = out_valid_reg;
    assign res_is_foreign    = out_foreign_reg;
    assign res_too_short     = out_short_reg;
    assign res_foreign_total = out_ftot_reg;
    assign res_latin_total   = out_ltot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            foreign_reg   <= '0;
            latin_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // in ST_CMP a freed slot is refilled below
            if (out_valid_reg && res_ready && (state_reg != ST_CMP)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_RUN: begin
                    if (ev_pop) begin
                        case (ev_code)
                            usrc_pkg::EV_LATIN: begin
                                if (latin_reg != '1) latin_reg <= latin_reg + 1'b1;
                            end
                            usrc_pkg::EV_FOREIGN: begin
                                if (foreign_reg != '1) foreign_reg <= foreign_reg + 1'b1;
                            end
                            usrc_pkg::EV_TERM: begin
                                state_reg <= ST_MUL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_f_reg <= ProdW'(foreign_reg) * ProdW'(usrc_pkg::PERCENT);
                    prod_t_reg <= ProdW'({1'b0, limit} + 8'd1) * ProdW'(total);
                    short_reg  <= (total < TotW'(usrc_pkg::MIN_TOTAL));
                    state_reg  <= ST_CMP;
                end
                ST_CMP: begin
                    // wait until the output register is free
                    if (slot_free) begin
                        out_valid_reg   <= 1'b1;
                        out_short_reg   <= short_reg;
                        out_foreign_reg <= !short_reg && (prod_f_reg >= prod_t_reg);
                        out_ftot_reg    <= sat_out(foreign_reg);
                        out_ltot_reg    <= sat_out(latin_reg);
                        foreign_reg     <= '0;
                        latin_reg       <= '0;
                        state_reg       <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/utf8_script_ratio_classifier_core.sv
// UTF-8 script ratio classifier: top level with the limit register.
// Instantiates usrc_front, usrc_fifo and usrc_back; uses usrc_pkg.
//
// Usage: stream a zero-terminated UTF-8 string one byte per request on the
// s_ channel. Each zero byte produces one result request on the m_ channel
// carrying the foreign and Latin tallies and the is_foreign / too_short flags.
// Throughput: one byte per cycle while the event queue has room. The decoder
// hands events to the tally unit through a four-entry queue.
// Path: a terminator accepted into the queue is popped by the tally unit, then
// passes the product stage and the compare stage before m_tvalid rises; the tally
// unit pops no events meanwhile, during which the queue absorbs bytes.
// The result sits in an output register; while the receiver stalls, counting
// of the next string continues and only the next terminator waits for it.
// Reset (aresetn low, synchronous) clears the decoder, queue and tallies and
// sets the limit to 50. The user writes the limit through cfg_valid/cfg_data
// only while the block is idle, which it does not enforce; cfg_ready is always high.
`default_nettype none

module utf8_script_ratio_classifier_core #(
    parameter int TALLY_WIDTH = usrc_pkg::TALLY_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [0] is_foreign, [1] too_short,
                                        // [17:2] foreign_total, [33:18] latin_total, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data   // [6:0] foreign_percent_limit
);

    logic [usrc_pkg::LIMIT_WIDTH-1:0] limit_reg;
    logic                             ev_push, ev_pop;
    usrc_pkg::ev_t                    push_code, pop_code;
    usrc_pkg::q_status_t              q_status;
    logic                             is_foreign, too_short;
    logic [usrc_pkg::OUT_WIDTH-1:0]   foreign_total, latin_total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= usrc_pkg::LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    usrc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .q_full     (q_status.full),
        .byte_ready (s_tready),
        .ev_push    (ev_push),
        .ev_code    (push_code)
    );

    usrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_push),
        .push_code (push_code),
        .pop       (ev_pop),
        .pop_code  (pop_code),
        .status    (q_status)
    );

    usrc_back #(
        .TALLY_WIDTH (TALLY_WIDTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .limit             (limit_reg),
        .ev_code           (pop_code),
        .q_status          (q_status),
        .ev_pop            (ev_pop),
        .res_valid         (m_tvalid),
        .res_ready         (m_tready),
        .res_is_foreign    (is_foreign),
        .res_too_short     (too_short),
        .res_foreign_total (foreign_total),
        .res_latin_total   (latin_total)
    );

    assign m_tdata = {6'd0, latin_total, foreign_total, too_short, is_foreign};

endmodule

`default_nettype wire

// File: verif/tb_utf8_script_ratio_classifier_core.sv
// Self-checking testbench for utf8_script_ratio_classifier_core: UTF-8 byte strings in,
// one script-ratio verdict per terminator out, checked against an in-bench predictor.
// Depends on usrc_pkg and the core RTL only.
`default_nettype none

module tb_utf8_script_ratio_classifier_core;

    localparam int unsigned TALLY_MAX     = (1 << usrc_pkg::TALLY_WIDTH_DEF) - 1;
    localparam int unsigned OUT_MAX       = 16'hFFFF;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          GROUP_BYTES   = 85;

    typedef struct packed {
        bit        is_foreign;
        bit        too_short;
        bit [15:0] foreign_total;
        bit [15:0] latin_total;
    } verdict_t;

    class ratio_scoreboard;
        bit [usrc_pkg::LIMIT_WIDTH-1:0] limit;
        bit [1:0]             pend_bytes;
        bit [20:0]            cp_acc;
        int unsigned          foreign_cnt;
        int unsigned          latin_cnt;
        verdict_t             verdicts[$];
        int unsigned          mismatches;
        int unsigned          results_seen;

        function new();
            limit        = usrc_pkg::LIMIT_RESET;
            mismatches   = 0;
            results_seen = 0;
            clear_string();
        endfunction

        function void clear_string();
            pend_bytes  = 2'd0;
            cp_acc      = '0;
            foreign_cnt = 0;
            latin_cnt   = 0;
        endfunction

        function bit foreign_cp(input bit [20:0] cp);
            return (cp >= 'h0600 && cp <= 'h06FF) || (cp >= 'h0400 && cp <= 'h04FF) ||
                   (cp >= 'h4E00 && cp <= 'h9FFF) || (cp >= 'h3040 && cp <= 'h30FF) ||
                   (cp >= 'hAC00 && cp <= 'hD7A3) || (cp >= 'h0E00 && cp <= 'h0E7F) ||
                   (cp >= 'h0590 && cp <= 'h05FF) || (cp >= 'h0900 && cp <= 'h097F) ||
                   (cp >= 'h0B80 && cp <= 'h0BFF);
        endfunction

        function int unsigned outstanding();
            return verdicts.size();
        endfunction

        // advance the predicted decoder by one accepted byte request
        function void note_byte(input bit [7:0] b);
            verdict_t    v;
            int unsigned total;
            if (b == 8'h00) begin
                total           = foreign_cnt + latin_cnt;
                v.too_short     = total < usrc_pkg::MIN_TOTAL;
                v.is_foreign    = !v.too_short &&
                                  ((foreign_cnt * usrc_pkg::PERCENT) / total > limit);
                v.foreign_total = 16'((foreign_cnt > OUT_MAX) ? OUT_MAX : foreign_cnt);
                v.latin_total   = 16'((latin_cnt > OUT_MAX) ? OUT_MAX : latin_cnt);
                verdicts.push_back(v);
                clear_string();
            end else if (pend_bytes != 0) begin
                cp_acc     = {cp_acc[14:0], b[5:0]};
                pend_bytes = pend_bytes - 2'd1;
                if (pend_bytes == 0) begin
                    if (foreign_cp(cp_acc)) begin
                        if (foreign_cnt < TALLY_MAX) foreign_cnt++;
                    end else if (cp_acc >= 'h00C0 && cp_acc <= 'h024F) begin
                        if (latin_cnt < TALLY_MAX) latin_cnt++;
                    end
                    cp_acc = '0;
                end
            end else if (b < 8'h80) begin
                if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9"))
                    if (latin_cnt < TALLY_MAX) latin_cnt++;
            end else if ((b & 8'hE0) == 8'hC0) begin
                cp_acc     = 21'(b[4:0]);
                pend_bytes = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                cp_acc     = 21'(b[3:0]);
                pend_bytes = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                cp_acc     = 21'(b[2:0]);
                pend_bytes = 2'd3;
            end
        endfunction

        function void check_result(input bit [39:0] d);
            verdict_t got;
            verdict_t want;
            got = {d[0], d[1], d[17:2], d[33:18]};
            results_seen++;
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected verdict fgn=%0b short=%0b f=%0d l=%0d",
                             got.is_foreign, got.too_short, got.foreign_total,
                             got.latin_total);
                return;
            end
            want = verdicts.pop_front();
            if (got.is_foreign != want.is_foreign || got.too_short != want.too_short ||
                got.foreign_total != want.foreign_total ||
                got.latin_total != want.latin_total) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: verdict %0d exp fgn=%0b short=%0b f=%0d l=%0d",
                             results_seen, want.is_foreign, want.too_short,
                             want.foreign_total, want.latin_total);
                    $display("       got fgn=%0b short=%0b f=%0d l=%0d",
                             got.is_foreign, got.too_short, got.foreign_total,
                             got.latin_total);
                end
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = 7'd0;

    ratio_scoreboard sb;
    int          s_idle_pct   = 37;
    int          r_idle_pct   = 65;
    int unsigned bytes_sent   = 0;
    int unsigned strings_sent = 0;
    int unsigned cycles       = 0;
    bit [7:0]    str_q[$];

    int unsigned range_lo[9] = '{'h0600, 'h0400, 'h4E00, 'h3040, 'hAC00, 'h0E00, 'h0590,
                                 'h0900, 'h0B80};
    int unsigned range_hi[9] = '{'h06FF, 'h04FF, 'h9FFF, 'h30FF, 'hD7A3, 'h0E7F, 'h05FF,
                                 'h097F, 'h0BFF};
    int unsigned edges[38]   = '{'h05FF, 'h0600, 'h06FF, 'h0700, 'h03FF, 'h0400, 'h04FF,
                                 'h0500, 'h4DFF, 'h4E00, 'h9FFF, 'hA000, 'h303F, 'h3040,
                                 'h30FF, 'h3100, 'hABFF, 'hAC00, 'hD7A3, 'hD7A4, 'h0DFF,
                                 'h0E00, 'h0E7F, 'h0E80, 'h058F, 'h0590, 'h08FF, 'h0900,
                                 'h097F, 'h0980, 'h0B7F, 'h0B80, 'h0BFF, 'h0C00, 'h00BF,
                                 'h00C0, 'h024F, 'h0250};

    utf8_script_ratio_classifier_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_utf8_script_ratio_classifier_core failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // encode one code point; mangle swaps a continuation byte for any nonzero byte
    function automatic void put_cp(input int unsigned cp, input bit mangle);
        bit [7:0] seq[$];
        int       pos;
        if (cp < 'h80)
            seq = '{cp[7:0]};
        else if (cp < 'h800)
            seq = '{8'hC0 | cp[10:6], 8'h80 | cp[5:0]};
        else if (cp < 'h10000)
            seq = '{8'hE0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
        else
            seq = '{8'hF0 | cp[20:18], 8'h80 | cp[17:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
        if (mangle && seq.size() > 1) begin
            pos      = $urandom_range(seq.size() - 1, 1);
            seq[pos] = 8'($urandom_range(255, 1));
        end
        foreach (seq[i]) str_q.push_back(seq[i]);
    endfunction

    function automatic int unsigned pick_cp(input int foreign_pct);
        int unsigned k;
        int unsigned r;
        if ($urandom_range(99) < foreign_pct) begin
            r = $urandom_range(8);
            return $urandom_range(range_hi[r], range_lo[r]);
        end
        k = $urandom_range(9);
        if (k < 5) begin
            r = $urandom_range(61);
            return (r < 26) ? "A" + r : (r < 52) ? "a" + r - 26 : "0" + r - 52;
        end
        if (k == 5) return $urandom_range(127, 1);
        if (k < 8)  return $urandom_range('h24F, 'hC0);
        if (k == 8) return edges[$urandom_range(37)];
        return $urandom_range('h1FFFFF, 'h80);
    endfunction

    // mostly well-formed text with invalid leads, noise and cut-off sequences mixed in
    function automatic void build_string(input int nchars, input int foreign_pct);
        int kind;
        int conts;
        str_q.delete();
        for (int i = 0; i < nchars; i++) begin
            kind = $urandom_range(99);
            if (kind < 4)
                str_q.push_back($urandom_range(1) ? 8'($urandom_range('hBF, 'h80))
                                                  : 8'($urandom_range('hFF, 'hF8)));
            else if (kind < 8)
                str_q.push_back(8'($urandom_range(255, 1)));
            else
                put_cp(pick_cp(foreign_pct), kind < 12);
        end
        if ($urandom_range(9) == 0) begin
            conts = $urandom_range(2);
            case (conts)
                0: str_q.push_back(8'hC0 | 8'($urandom_range(31)));
                1: str_q.push_back(8'hE0 | 8'($urandom_range(15)));
                default: str_q.push_back(8'hF0 | 8'($urandom_range(7)));
            endcase
            for (int i = 0; i < conts; i++) str_q.push_back(8'h80 | 8'($urandom_range(63)));
        end
        str_q.push_back(8'h00);
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_byte(input bit [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < s_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
        if (b == 8'h00) strings_sent++;
        @(negedge aclk);
    endtask

    task automatic send_queue();
        foreach (str_q[i]) send_byte(str_q[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input bit [6:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        bit [6:0]    limits[7];
        int unsigned group_start;
        sb = new();
        limits = '{7'd0, 7'd100, 7'd127, 7'($urandom_range(127)), 7'd1, 7'd99,
                   7'($urandom_range(127))};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty string, ASCII extremes and invalid leads, cut-off sequence,
        // then range edges and a 4-byte code point under the reset limit
        str_q = '{8'h00,
                  "A", "z", "0", "9", "Z", "a", 8'h7F, 8'h01, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                  8'hE4, 8'h00,
                  "a", "1", 8'hC3, 8'h80, 8'hC9, 8'h8F, 8'hE4, 8'hB8, 8'h80, 8'hD0, 8'h80,
                  8'hED, 8'h9E, 8'hA3, 8'hF0, 8'h9F, 8'h98, 8'h80, "b", "c", "d", "e",
                  8'h00};
        send_queue();

        for (int g = 0; g < 7; g++) begin
            drain();
            s_idle_pct = (g < 2) ? 37 : (g < 4) ? 65 : 0;
            r_idle_pct = (g < 2) ? 65 : (g < 4) ? 37 : 0;
            write_limit(limits[g]);
            group_start = bytes_sent;
            while (bytes_sent - group_start < GROUP_BYTES) begin
                build_string($urandom_range(3) == 0 ? $urandom_range(9) : $urandom_range(20, 5),
                             $urandom_range(100));
                send_queue();
            end
        end
        drain();

        $display("Sent %0d bytes in %0d strings under several limits,",
                 bytes_sent, strings_sent);
        $display("idle mixes 37/65, 65/37 and 0/0; %0d verdicts checked, %0d mismatches.",
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_utf8_script_ratio_classifier_core passed");
        else
            $display("tb_utf8_script_ratio_classifier_core failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/usrc_pkg.sv
hdl/usrc_front.sv
hdl/usrc_fifo.sv
hdl/usrc_back.sv
hdl/utf8_script_ratio_classifier_core.sv
verif/tb_utf8_script_ratio_classifier_core.sv
